// ===== rtl/qu48_pkg.sv =====
// Shared types, widths and helpers for the packed quaternion decoder.
// Most widths derive from FRACTION_BITS; the input, field, scale and port widths are fixed. No dependencies.
package qu48_pkg;

    localparam int FRACTION_BITS = 16;

    // Packed input layout.
    localparam int IN_W     = 48;
    localparam int FIELD_W  = 15;
    localparam int LANES    = 3;
    localparam logic [FIELD_W-1:0] CENTER = FIELD_W'(16384);

    // Scale 0.70710678 / 16384 held as round(0.70710678 * 2^32).
    localparam int SCALE_W = 32;
    localparam logic [SCALE_W-1:0] SCALE_Q32 = 32'd3037000495;
    localparam int PROD_W  = FIELD_W + SCALE_W;
    localparam int SHIFT   = 46 - FRACTION_BITS;
    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (SHIFT - 1);

    // Component magnitude, signed component and squares.
    localparam int QW    = FRACTION_BITS;
    localparam int CW    = FRACTION_BITS + 1;
    localparam int SQ_W  = 2 * FRACTION_BITS;
    localparam int SUM_W = 2 * FRACTION_BITS + 2;

    // Square root: radicand padded to an even width, one root bit per cell.
    localparam int RAD_W  = 2 * FRACTION_BITS + 2;
    localparam int NCELL  = RAD_W / 2;
    localparam int ROOT_W = NCELL;
    localparam int REM_W  = ROOT_W + 1;
    localparam int TRY_W  = REM_W + 2;
    localparam logic [RAD_W-1:0] ONE_SQ = RAD_W'(1) << (2 * FRACTION_BITS);

    // Rebuilt component after rounding and sign, and the port width.
    localparam int WW    = FRACTION_BITS + 2;
    localparam int OUT_W = 18;

    // Position of the rebuilt component.
    localparam logic [1:0] SLOT_FIRST  = 2'd0;
    localparam logic [1:0] SLOT_SECOND = 2'd1;
    localparam logic [1:0] SLOT_THIRD  = 2'd2;
    localparam logic [1:0] SLOT_FOURTH = 2'd3;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic [1:0]           slot;
        logic                 negate;
    } t_side;

    typedef struct packed {
        logic              valid;
        logic [RAD_W-1:0]  rad;
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rem;
        t_side             side;
    } t_sqrt;

    // Sign-extend or truncate a signed value to the port width.
    function automatic logic [OUT_W-1:0] to_field(input logic signed [WW-1:0] v);
        logic signed [63:0] e;
        e = 64'(v);
        return e[OUT_W-1:0];
    endfunction

endpackage

// ===== rtl/qu48_sqrt_cell.sv =====
// One cell of the square root chain: resolves one root bit per cycle while the pipeline advances.
// Depends on qu48_pkg.
module qu48_sqrt_cell
    import qu48_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  t_sqrt i_cell,
    output t_sqrt o_cell
);

    t_sqrt             r_cell;
    t_sqrt             n_cell;
    logic [TRY_W-1:0]  acc;
    logic [TRY_W-1:0]  trial;
    logic [TRY_W-1:0]  diff;
    logic              take;

    always_comb begin
        acc   = {i_cell.rem, i_cell.rad[RAD_W-1 -: 2]};
        trial = TRY_W'({i_cell.root, 2'b01});
        take  = (acc >= trial);
        diff  = acc - trial;

        n_cell       = i_cell;
        n_cell.rad   = i_cell.rad << 2;
        n_cell.root  = {i_cell.root[ROOT_W-2:0], take};
        n_cell.rem   = take ? diff[REM_W-1:0] : acc[REM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_adv) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

// ===== rtl/qu48_front.sv =====
// Front pipeline: unpack, scale, square, sum and form the radicand.
// Depends on qu48_pkg; feeds the head of the square root chain.
module qu48_front
    import qu48_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  logic [IN_W-1:0] i_packed_quaternion,
    output t_sqrt           o_head
);

    typedef struct packed {
        logic                         valid;
        logic [LANES-1:0][PROD_W-1:0] prod;
        logic [LANES-1:0]             neg;
        logic [1:0]                   slot;
        logic                         negate;
    } t_stg_a;

    typedef struct packed {
        logic                     valid;
        logic [LANES-1:0][QW-1:0] q;
        t_side                    side;
    } t_stg_b;

    typedef struct packed {
        logic                       valid;
        logic [LANES-1:0][SQ_W-1:0] sq;
        t_side                      side;
    } t_stg_c;

    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] sum;
        t_side            side;
    } t_stg_d;

    t_stg_a r_a, n_a;
    t_stg_b r_b, n_b;
    t_stg_c r_c, n_c;
    t_stg_d r_d, n_d;
    t_sqrt  r_e, n_e;

    logic [LANES-1:0][FIELD_W-1:0] fld;
    logic [LANES-1:0][FIELD_W-1:0] mag;
    logic [LANES-1:0][CW-1:0]      comp;
    logic [LANES-1:0][PROD_W-1:0]  rounded;

    assign fld = {i_packed_quaternion[46:32], i_packed_quaternion[30:16],
                  i_packed_quaternion[14:0]};

    // Stage A: recenter each field and multiply its magnitude by the scale.
    always_comb begin
        n_a.valid  = i_valid;
        n_a.slot   = {i_packed_quaternion[15], i_packed_quaternion[31]};
        n_a.negate = i_packed_quaternion[47];
        for (int k = 0; k < LANES; k++) begin
            n_a.neg[k]  = (fld[k] < CENTER);
            mag[k]      = n_a.neg[k] ? (CENTER - fld[k]) : (fld[k] - CENTER);
            n_a.prod[k] = PROD_W'(mag[k]) * PROD_W'(SCALE_Q32);
        end
    end

    // Stage B: round the magnitude to nearest and attach the sign.
    always_comb begin
        n_b.valid       = r_a.valid;
        n_b.side.slot   = r_a.slot;
        n_b.side.negate = r_a.negate;
        for (int k = 0; k < LANES; k++) begin
            rounded[k] = (r_a.prod[k] + HALF) >> SHIFT;
            n_b.q[k]   = rounded[k][QW-1:0];
            comp[k]    = r_a.neg[k] ? (CW'(0) - CW'(n_b.q[k])) : CW'(n_b.q[k]);
        end
        n_b.side.x = comp[0];
        n_b.side.y = comp[1];
        n_b.side.z = comp[2];
    end

    // Stage C: exact squares of the magnitudes.
    always_comb begin
        n_c.valid = r_b.valid;
        n_c.side  = r_b.side;
        for (int k = 0; k < LANES; k++) begin
            n_c.sq[k] = SQ_W'(r_b.q[k]) * SQ_W'(r_b.q[k]);
        end
    end

    // Stage D: sum of squares.
    always_comb begin
        n_d.valid = r_c.valid;
        n_d.side  = r_c.side;
        n_d.sum   = SUM_W'(r_c.sq[0]) + SUM_W'(r_c.sq[1]) + SUM_W'(r_c.sq[2]);
    end

    // Stage E: one minus the sum, clamped at zero, seeds the root chain.
    always_comb begin
        n_e.valid = r_d.valid;
        n_e.side  = r_d.side;
        n_e.rad   = (RAD_W'(r_d.sum) < ONE_SQ) ? (ONE_SQ - RAD_W'(r_d.sum)) : '0;
        n_e.root  = '0;
        n_e.rem   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
            r_b.valid <= 1'b0;
            r_c.valid <= 1'b0;
            r_d.valid <= 1'b0;
            r_e.valid <= 1'b0;
        end else if (i_adv) begin
            r_a <= n_a;
            r_b <= n_b;
            r_c <= n_c;
            r_d <= n_d;
            r_e <= n_e;
        end
    end

    assign o_head = r_e;

endmodule

// ===== rtl/quaternion48_unpack.sv =====
// Top level of the smallest-three quaternion decoder: front pipeline,
// square root cell chain and output register. Depends on qu48_pkg,
// qu48_front and qu48_sqrt_cell.
//
//   Channel  Direction  Handshake           Payload
//   input    in         i_valid / o_stall   i_packed_quaternion (48 bits)
//   output   out        o_valid / i_stall   o_comp_first .. o_comp_fourth (18 bits)
//
// One transaction is accepted per cycle unless o_stall is high; each passes
// through front stages A to E, the NCELL cells of the square root chain,
// which resolves one root bit per cell, and the output register.
// Reset is synchronous and active low; it clears only the valid bits.
// While a result waits under i_stall the whole pipeline holds in place.
module quaternion48_unpack
    import qu48_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [IN_W-1:0]  i_packed_quaternion,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [OUT_W-1:0] o_comp_first,
    output logic [OUT_W-1:0] o_comp_second,
    output logic [OUT_W-1:0] o_comp_third,
    output logic [OUT_W-1:0] o_comp_fourth
);

    // The pipeline moves as a whole; it only halts when the output register
    // holds a result that the downstream side is not taking.
    logic adv;

    t_sqrt w_chain [NCELL+1];

    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_comp [4];
    logic [OUT_W-1:0]      n_comp [4];

    logic [ROOT_W-1:0]     root;
    logic                  round_up;
    logic signed [WW-1:0]  w_mag;
    logic signed [WW-1:0]  w_val;
    logic [OUT_W-1:0]      fx, fy, fz, fw;

    assign o_stall = r_out_valid & i_stall;
    assign adv     = ~o_stall;

    qu48_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_adv               (adv),
        .i_valid             (i_valid),
        .i_packed_quaternion (i_packed_quaternion),
        .o_head              (w_chain[0])
    );

    // Each cell takes two radicand bits and produces one root bit.
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        qu48_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_cell  (w_chain[g]),
            .o_cell  (w_chain[g+1])
        );
    end

    // The chain leaves the floor root and the remainder n - root^2. Rounding
    // to nearest adds one when the remainder exceeds the root.
    always_comb begin
        root     = w_chain[NCELL].root;
        round_up = (w_chain[NCELL].rem > REM_W'(root));
        w_mag    = WW'(root) + WW'(round_up);
        // A negated zero stays zero, since two's complement has no minus zero.
        w_val    = w_chain[NCELL].side.negate ? (WW'(0) - w_mag) : w_mag;

        fx = to_field(WW'(w_chain[NCELL].side.x));
        fy = to_field(WW'(w_chain[NCELL].side.y));
        fz = to_field(WW'(w_chain[NCELL].side.z));
        fw = to_field(w_val);

        unique case (w_chain[NCELL].side.slot)
            SLOT_FIRST: begin
                n_comp[0] = fw; n_comp[1] = fx; n_comp[2] = fy; n_comp[3] = fz;
            end
            SLOT_SECOND: begin
                n_comp[0] = fx; n_comp[1] = fw; n_comp[2] = fy; n_comp[3] = fz;
            end
            SLOT_THIRD: begin
                n_comp[0] = fx; n_comp[1] = fy; n_comp[2] = fw; n_comp[3] = fz;
            end
            SLOT_FOURTH: begin
                n_comp[0] = fx; n_comp[1] = fy; n_comp[2] = fz; n_comp[3] = fw;
            end
            default: begin
                n_comp[0] = fx; n_comp[1] = fy; n_comp[2] = fz; n_comp[3] = fw;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= w_chain[NCELL].valid;
            r_comp      <= n_comp;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_comp_first  = r_comp[0];
    assign o_comp_second = r_comp[1];
    assign o_comp_third  = r_comp[2];
    assign o_comp_fourth = r_comp[3];

    // A finished root moves into the output register whenever the pipe advances.
    a_tail_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && w_chain[NCELL].valid) |=> r_out_valid)
        else $error("finished root not captured by the output register");

    // The remainder of a finished root never exceeds twice the root.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_chain[NCELL].valid |->
            (TRY_W'(w_chain[NCELL].rem) <= (TRY_W'(w_chain[NCELL].root) << 1)))
        else $error("square root remainder out of range");

    // While the output is held, the end of the chain does not move.
    a_chain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!adv) |=> $stable(w_chain[NCELL]))
        else $error("root chain moved during a stall");

endmodule
